@@ src/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/tdes_pkg.sv @@
// Types, permutation tables and round functions for the triple DES pipeline
`default_nettype none
package tdes_pkg;

    typedef struct packed {
        logic valid;
        logic bypass;
        logic mac;
        logic last;
        logic err;
    } ctl_t;

    localparam int NUM_CELLS = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] REG_KEY_ONE     = 3'd0;
    localparam logic [2:0] REG_KEY_TWO     = 3'd1;
    localparam logic [2:0] REG_KEY_THREE   = 3'd2;
    localparam logic [2:0] REG_KEY_MODE    = 3'd3;
    localparam logic [2:0] REG_DIRECTION   = 3'd4;
    localparam logic [2:0] REG_CIPHER_MODE = 3'd5;

    localparam logic [1:0] KEY_SINGLE  = 2'd0;
    localparam logic [1:0] KEY_TWO     = 2'd1;
    localparam logic [1:0] KEY_THREE   = 2'd2;
    localparam logic [1:0] KEY_INVALID = 2'd3;

    localparam logic [7:0] T_IP [0:63] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,
        59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam logic [7:0] T_FP [0:63] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,
        35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam logic [7:0] T_E [0:47] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,
        12,13,14,15,16,17,16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [7:0] T_P [0:31] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam logic [7:0] T_PC1 [0:55] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,
        30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
    localparam logic [7:0] T_PC2 [0:47] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,
        26,8,16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,
        34,53,46,42,50,36,29,32};
    localparam int ROT_CUM [0:15] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
    localparam logic [3:0] SBOX [0:511] = '{
        14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
        15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
        10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
        7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
        2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
        12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
        4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
        13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11};

    function automatic logic [63:0] ip_perm(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(T_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(T_FP[i])];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] rv, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] o;
        logic [31:0] p;
        logic [5:0]  b;
        e = '0;
        o = '0;
        p = '0;
        for (int i = 0; i < 48; i++) e[47-i] = rv[32-int'(T_E[i])];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            b = e[47-6*i -: 6];
            o[31-4*i -: 4] = SBOX[i*64 + int'({b[5], b[0]})*16 + int'(b[4:1])];
        end
        for (int i = 0; i < 32; i++) p[31-i] = o[32-int'(T_P[i])];
        return p;
    endfunction

    function automatic logic [47:0] subkey(input logic [63:0] key, input int idx);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] rot;
        logic [47:0] k;
        cd = '0;
        k  = '0;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(T_PC1[i])];
        c = cd[55:28];
        d = cd[27:0];
        c = (c << ROT_CUM[idx]) | (c >> (28 - ROT_CUM[idx]));
        d = (d << ROT_CUM[idx]) | (d >> (28 - ROT_CUM[idx]));
        rot = {c, d};
        for (int i = 0; i < 48; i++) k[47-i] = rot[56-int'(T_PC2[i])];
        return k;
    endfunction

endpackage
`default_nettype wire

@@ src/triple_des_ecb_cbc_mac.sv @@
// Top level: triple DES engine, ECB and CBC-MAC, over a 48-cell round chain
// Usage:
//  Input words (s_) carry a 64-bit block, its valid byte count and a last flag;
//  result words (m_) carry the output block and a status bit. Both channels are
//  valid/ready. Keys and modes are written through cfg_wr_en/cfg_addr/cfg_data
//  while the block is idle.
//  Path: an accepted word passes through the 48 round cells, and the 48th
//  round cell feeds the output register behind m_valid. Bad-key words, and
//  in ECB partial words, run the same chain unciphered, so order is kept.
//  Throughput: ECB takes one word per cycle unless the receiver stalls.
//  CBC-MAC waits for an empty pipeline: each word needs the prior chain value.
//  A stalled receiver freezes the whole chain; s_ready falls with it.
//  Reset clears all pipeline valid bits, the MAC chain and error flag, and
//  sets the registers to their defaults (two-key, encrypt, ECB).
`default_nettype none
module triple_des_ecb_cbc_mac (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [tdes_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_block,
    input  wire logic [3:0]  s_byte_count,
    input  wire logic        s_is_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_block,
    output logic             m_status
);
    localparam int N = tdes_pkg::NUM_CELLS;

    logic [63:0] key_one_reg, key_two_reg, key_three_reg;
    logic [1:0]  key_mode_reg;
    logic        direction_reg, cipher_mode_reg;
    logic [63:0] chain_reg, chain_next;
    logic        sticky_reg, sticky_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_block_reg, out_block_next;
    logic        out_status_reg, out_status_next;

    tdes_pkg::ctl_t ctl [0:N];
    logic [63:0]    lr [0:N];
    logic [N-1:0]   busy;
    logic [63:0]    unit_key [0:2];
    logic           unit_dec [0:2];
    logic           en, enc, pipe_empty, bad_key;
    logic [63:0]    mask, masked, ex_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_one_reg     <= '0;
            key_two_reg     <= '0;
            key_three_reg   <= '0;
            key_mode_reg    <= tdes_pkg::KEY_TWO;
            direction_reg   <= 1'b1;
            cipher_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tdes_pkg::REG_KEY_ONE:     key_one_reg     <= cfg_data;
                tdes_pkg::REG_KEY_TWO:     key_two_reg     <= cfg_data;
                tdes_pkg::REG_KEY_THREE:   key_three_reg   <= cfg_data;
                tdes_pkg::REG_KEY_MODE:    key_mode_reg    <= cfg_data[1:0];
                tdes_pkg::REG_DIRECTION:   direction_reg   <= cfg_data[0];
                tdes_pkg::REG_CIPHER_MODE: cipher_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // EDE unit keys; single DES runs K1 through all three units
    always_comb begin
        logic [63:0] k3;
        enc = cipher_mode_reg | direction_reg;
        case (key_mode_reg)
            tdes_pkg::KEY_THREE: k3 = key_three_reg;
            default:             k3 = key_one_reg;
        endcase
        if (key_mode_reg == tdes_pkg::KEY_SINGLE) begin
            unit_key[0] = key_one_reg;
            unit_key[1] = key_one_reg;
            unit_key[2] = key_one_reg;
        end else begin
            unit_key[0] = enc ? key_one_reg : k3;
            unit_key[1] = key_two_reg;
            unit_key[2] = enc ? k3 : key_one_reg;
        end
        unit_dec[0] = ~enc;
        unit_dec[1] = enc;
        unit_dec[2] = ~enc;
    end

    assign bad_key    = (key_mode_reg == tdes_pkg::KEY_INVALID);
    assign en         = ~out_valid_reg | m_ready;
    assign pipe_empty = ~|busy;
    assign s_ready    = en & (~cipher_mode_reg | pipe_empty);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            mask[63-8*b -: 8] = (4'(b) < s_byte_count) ? 8'hff : 8'h00;
        end
    end
    assign masked = s_data_block & mask;

    always_comb begin
        ctl[0].valid = s_valid & s_ready;
        ctl[0].mac   = cipher_mode_reg;
        ctl[0].last  = s_is_last;
        ctl[0].err   = bad_key;
        if (cipher_mode_reg) begin
            ctl[0].bypass = bad_key;
            lr[0] = bad_key ? (chain_reg ^ masked) : tdes_pkg::ip_perm(chain_reg ^ masked);
        end else if (bad_key) begin
            ctl[0].bypass = 1'b1;
            lr[0] = '0;
        end else if (s_byte_count >= 4'd8) begin
            ctl[0].bypass = 1'b0;
            lr[0] = tdes_pkg::ip_perm(s_data_block);
        end else begin
            ctl[0].bypass = 1'b1;
            lr[0] = ~s_data_block & mask;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        tdes_cell #(
            .ROUND (g % 16),
            .SWAP  ((g % 16) == 15)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .key     (unit_key[g / 16]),
            .dec     (unit_dec[g / 16]),
            .ctl_in  (ctl[g]),
            .lr_in   (lr[g]),
            .ctl_out (ctl[g+1]),
            .lr_out  (lr[g+1])
        );
        assign busy[g] = ctl[g+1].valid;
    end

    assign ex_val = ctl[N].bypass ? lr[N] : tdes_pkg::fp_perm(lr[N]);

    always_comb begin
        chain_next      = chain_reg;
        sticky_next     = sticky_reg;
        out_valid_next  = out_valid_reg & ~m_ready;
        out_block_next  = out_block_reg;
        out_status_next = out_status_reg;
        if (en && ctl[N].valid) begin
            if (ctl[N].mac) begin
                chain_next  = ex_val;
                sticky_next = sticky_reg | ctl[N].err;
                if (ctl[N].last) begin
                    out_valid_next  = 1'b1;
                    out_block_next  = sticky_next ? 64'd0 : ex_val;
                    out_status_next = sticky_next;
                    chain_next      = '0;
                    sticky_next     = 1'b0;
                end
            end else begin
                out_valid_next  = 1'b1;
                out_block_next  = ex_val;
                out_status_next = ctl[N].err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg     <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            chain_reg     <= chain_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_block_reg  <= out_block_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_out_block = out_block_reg;
    assign m_status    = out_status_reg;
endmodule
`default_nettype wire

@@ src/tdes_cell.sv @@
// One registered DES round cell of the 48-round chain
`default_nettype none
module tdes_cell #(
    parameter int ROUND = 0,
    parameter bit SWAP  = 1'b0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic [63:0]   key,
    input  wire logic          dec,
    input  wire tdes_pkg::ctl_t ctl_in,
    input  wire logic [63:0]   lr_in,
    output tdes_pkg::ctl_t     ctl_out,
    output logic [63:0]        lr_out
);
    tdes_pkg::ctl_t ctl_reg;
    logic [63:0]    lr_reg;
    logic [63:0]    lr_next;
    logic [47:0]    k;
    logic [31:0]    nr;

    assign k  = dec ? tdes_pkg::subkey(key, 15 - ROUND) : tdes_pkg::subkey(key, ROUND);
    assign nr = lr_in[63:32] ^ tdes_pkg::feistel(lr_in[31:0], k);

    always_comb begin
        if (ctl_in.bypass) begin
            lr_next = lr_in;
        end else if (SWAP) begin
            lr_next = {nr, lr_in[31:0]};
        end else begin
            lr_next = {lr_in[31:0], nr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lr_reg <= lr_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign lr_out  = lr_reg;
endmodule
`default_nettype wire

@@ src/tdes_checker.sv @@
// Port-level checker for the triple DES engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tdes_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_out_block,
    input wire logic        m_status
);
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_out_block))
    `ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_status, m_out_block == 64'd0)
    `ASSERT_NOW(a_stall_in, aclk, aresetn, m_valid && !m_ready, !s_ready)
endmodule

bind triple_des_ecb_cbc_mac tdes_checker u_tdes_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_block (m_out_block),
    .m_status    (m_status)
);
`default_nettype wire
